@@ sv/ldh_pkg.sv @@
// ----------------------------------------------------------------------------
// ldh_pkg: shared types and constants of the Lanczos-3 half downscaler
// Fixed-point widths, kernel taps, cell control and state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package ldh_pkg;

  // Sizing
  localparam int MAX_SOURCE_WIDTH   = 512;
  localparam int COEF_FRACTION_BITS = 14;

  localparam int LIM_OW    = (MAX_SOURCE_WIDTH / 2 < 256) ? MAX_SOURCE_WIDTH / 2 : 256;
  localparam int SRC_W_MAX = 2 * LIM_OW;
  localparam int COL_W     = (SRC_W_MAX > 2) ? $clog2(SRC_W_MAX) : 1;

  localparam int OW_W   = 9;
  localparam int OH_W   = 12;
  localparam int ROW_W  = 12;
  localparam int OCOL_W = 8;
  localparam int OROW_W = 11;
  localparam int CFG_W  = 12;
  localparam int LINES  = 5;
  localparam int TAPS   = 6;
  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;

  // Kernel values L(0.5), L(1.5), L(2.5) with 24 fraction bits, rounded half up
  localparam int KSH  = 24 - COEF_FRACTION_BITS;
  localparam int KRND = (KSH > 0) ? (1 << (KSH - 1)) : 0;
  localparam int K0   = (10199324 + KRND) >> KSH;
  localparam int K1   = (2266517 + KRND) >> KSH;
  localparam int K2   = (407973 + KRND) >> KSH;

  // Arithmetic widths
  localparam int W_W    = COEF_FRACTION_BITS + 1;
  localparam int SUM_W  = COEF_FRACTION_BITS + 4;
  localparam int V_W    = COEF_FRACTION_BITS + 11;
  localparam int PROD_W = V_W + W_W;
  localparam int NUM_W  = PROD_W + 3;
  localparam int DEN_W  = 2 * SUM_W;
  localparam int Q_W    = 11;
  localparam int DV_W   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  // Register indexes
  localparam logic CFG_OUT_WIDTH  = 1'b0;
  localparam logic CFG_OUT_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0]           pix_t;
  typedef pix_t [TAPS-1:0]            col_t;
  typedef logic signed [W_W-1:0]      wgt_t;
  typedef wgt_t [TAPS-1:0]            wvec_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [V_W-1:0]      vsum_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef prod_t [2:0]                prod3_t;
  typedef logic signed [NUM_W-1:0]    num_t;
  typedef num_t [2:0]                 num3_t;
  typedef logic signed [DEN_W-1:0]    den_t;
  typedef logic [2:0][CH_W-1:0]       quot3_t;

  typedef struct packed {
    logic shift;
    logic vsum;
    logic hprod;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WGT,
    ST_VSUM,
    ST_HPROD,
    ST_HSUM,
    ST_DSTART,
    ST_DWAIT,
    ST_EMIT
  } ldh_state_e;

  // Kernel weight of tap t (0..5), taps 1 and 4 negative
  function automatic wgt_t tap_weight(input int t);
    wgt_t w;
    if (t inside {2, 3}) begin
      w = W_W'(K0);
    end else if (t inside {1, 4}) begin
      w = W_W'(-K1);
    end else begin
      w = W_W'(K2);
    end
    return w;
  endfunction

  // Weight of window slot j for output coordinate o; zero outside the frame
  function automatic wgt_t slot_weight(input int cur, input int o, input int size,
                                       input int j);
    int   s;
    int   t;
    wgt_t w;
    s = cur - 5 + j;
    t = s - 2 * o + 2;
    if (s < 0 || s >= size || t < 0 || t > 5) begin
      w = '0;
    end else begin
      w = tap_weight(t);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

@@ sv/ldh_line_ram.sv @@
// ----------------------------------------------------------------------------
// ldh_line_ram: one source line of pixels
// Single port, read-first, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ldh_line_ram (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [ldh_pkg::COL_W-1:0] addr_i,
  input  wire ldh_pkg::pix_t            wdata_i,
  output ldh_pkg::pix_t                 rdata_o
);

  ldh_pkg::pix_t mem [ldh_pkg::SRC_W_MAX];

  // Read old contents, then write
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_o <= mem[addr_i];
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/ldh_column_cell.sv @@
// ----------------------------------------------------------------------------
// ldh_column_cell: one column of the 6x6 filter window
// Holds six rows, shifts to its neighbor, forms vertical and horizontal terms.
// ----------------------------------------------------------------------------
`default_nettype none

module ldh_column_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ldh_pkg::cell_ctrl_t ctrl_i,
  input  wire ldh_pkg::col_t       col_i,
  input  wire ldh_pkg::wvec_t      wy_i,
  input  wire ldh_pkg::wgt_t       wx_i,
  output ldh_pkg::col_t            col_o,
  output ldh_pkg::prod3_t          prod_o
);

  ldh_pkg::col_t        pix_q;
  ldh_pkg::vsum_t [2:0] v_q;
  ldh_pkg::vsum_t [2:0] v_d;
  ldh_pkg::prod3_t      prod_q;
  ldh_pkg::prod3_t      prod_d;

  // Vertical weighted sum per channel; skip rows with zero weight
  always_comb begin
    logic signed [ldh_pkg::CH_W:0] pv;
    for (int ch = 0; ch < 3; ch++) begin
      v_d[ch] = '0;
      for (int i = 0; i < ldh_pkg::TAPS; i++) begin
        pv = $signed({1'b0, pix_q[i][ldh_pkg::PIX_W-1-ldh_pkg::CH_W*ch -: ldh_pkg::CH_W]});
        if (wy_i[i] != '0) begin
          v_d[ch] = v_d[ch] + ldh_pkg::V_W'(pv * $signed(wy_i[i]));
        end
      end
    end
  end

  // Horizontal term per channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (wx_i != '0) begin
        prod_d[ch] = ldh_pkg::PROD_W'($signed(v_q[ch]) * $signed(wx_i));
      end else begin
        prod_d[ch] = '0;
      end
    end
  end

  // Window column shifts in from the newer neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (ctrl_i.shift) begin
      pix_q <= col_i;
    end
  end

  // Hold the arithmetic stages
  always_ff @(posedge clk_i) begin
    if (ctrl_i.vsum) begin
      v_q <= v_d;
    end
    if (ctrl_i.hprod) begin
      prod_q <= prod_d;
    end
  end

  assign col_o  = pix_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

@@ sv/ldh_divider.sv @@
// ----------------------------------------------------------------------------
// ldh_divider: three-channel restoring divider with a shared divisor
// One quotient bit per cycle, floored, clamped to 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module ldh_divider (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire ldh_pkg::num3_t num_i,
  input  wire ldh_pkg::den_t  den_i,
  output logic                done_o,
  output ldh_pkg::quot3_t     quot_o
);

  localparam int CNT_W = $clog2(ldh_pkg::Q_W + 1);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [ldh_pkg::DV_W-1:0]      dsh_q;
  logic [ldh_pkg::DV_W-1:0]      rem_q  [3];
  logic [ldh_pkg::Q_W-1:0]       q_q    [3];
  logic [2:0]                    zero_q;
  logic [2:0]                    sat_q;
  logic [ldh_pkg::DV_W-1:0]      dext;
  logic                          den_pos;

  assign den_pos = !den_i[ldh_pkg::DEN_W-1] && (den_i != '0);
  assign dext    = ldh_pkg::DV_W'(den_i[ldh_pkg::DEN_W-2:0]);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ldh_pkg::Q_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load operands, then subtract the shifted divisor one bit at a time
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dsh_q <= dext << (ldh_pkg::Q_W - 1);
      for (int ch = 0; ch < 3; ch++) begin
        rem_q[ch]  <= ldh_pkg::DV_W'(num_i[ch][ldh_pkg::NUM_W-2:0]);
        q_q[ch]    <= '0;
        zero_q[ch] <= num_i[ch][ldh_pkg::NUM_W-1] || !den_pos;
        sat_q[ch]  <= ldh_pkg::DV_W'(num_i[ch][ldh_pkg::NUM_W-2:0]) >=
                      (dext << ldh_pkg::Q_W);
      end
    end else if (busy_q) begin
      dsh_q <= dsh_q >> 1;
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_q[ch] >= dsh_q) begin
          rem_q[ch] <= rem_q[ch] - dsh_q;
          q_q[ch]   <= {q_q[ch][ldh_pkg::Q_W-2:0], 1'b1};
        end else begin
          q_q[ch]   <= {q_q[ch][ldh_pkg::Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // Clamp
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (zero_q[ch]) begin
        quot_o[ch] = '0;
      end else if (sat_q[ch] || (q_q[ch] > ldh_pkg::Q_W'(255))) begin
        quot_o[ch] = 8'hFF;
      end else begin
        quot_o[ch] = q_q[ch][ldh_pkg::CH_W-1:0];
      end
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

@@ sv/lanczos3_half_downscaler_top.sv @@
// ----------------------------------------------------------------------------
// A pixel that emits nothing passes only the accept and line-store read states.
// Each output pixel adds the weights, vertical and horizontal cell stages,
// sum, and the 11-step divider.
// A source pixel causes 0..4 outputs; no new one is taken until all are emitted.
// Reset: registers to 256x256 output, counters and column window cleared;
// line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// lanczos3_half_downscaler_top: 2x RGB downscaler with a Lanczos-3 kernel
// Five line stores feed a chain of six column cells and a shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lanczos3_half_downscaler_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [ldh_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // in_red [7:0], in_green [15:8], in_blue [23:16]
  input  wire logic [23:0]               s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // out_red [7:0], out_green [15:8], out_blue [23:16], out_col [31:24],
  // out_row [42:32], zero [47:43]
  output logic [47:0]                    m_axis_tdata,
  // run_end
  output logic                           m_axis_tlast,
  // frame_end
  output logic                           m_axis_tuser
);

  ldh_pkg::ldh_state_e state_q, state_d;

  logic [ldh_pkg::OW_W-1:0]   out_width_q;
  logic [ldh_pkg::OH_W-1:0]   out_height_q;
  logic [ldh_pkg::COL_W-1:0]  col_q;
  logic [ldh_pkg::ROW_W-1:0]  row_q;
  logic [2:0]                 bank_q;

  logic [ldh_pkg::COL_W-1:0]  cur_c_q;
  logic [ldh_pkg::ROW_W-1:0]  cur_r_q;
  logic [2:0]                 bank_cap_q;
  ldh_pkg::pix_t              px_q;
  logic [1:0]                 nr_q, nc_q;
  logic [ldh_pkg::OROW_W-1:0] rv0_q, rv1_q;
  logic [ldh_pkg::OCOL_W-1:0] cv0_q, cv1_q;
  logic                       a_q, b_q;
  ldh_pkg::wvec_t             wx_q, wy_q;
  ldh_pkg::den_t              den_q;
  ldh_pkg::num3_t             num_q;

  logic                       m_valid_q;
  logic [47:0]                m_data_q;
  logic                       m_last_q;
  logic                       m_user_q;

  logic                       accept;
  logic                       out_ld;
  logic                       div_start;
  logic                       div_done;
  ldh_pkg::quot3_t            quot;
  ldh_pkg::cell_ctrl_t        cell_ctrl;
  ldh_pkg::pix_t              in_px;
  ldh_pkg::pix_t              ram_rd [ldh_pkg::LINES];
  ldh_pkg::col_t              new_col;
  ldh_pkg::col_t              cell_col  [ldh_pkg::TAPS];
  ldh_pkg::prod3_t            cell_prod [ldh_pkg::TAPS];

  logic [ldh_pkg::OW_W-1:0]   ow_eff;
  logic [ldh_pkg::OH_W-1:0]   oh_eff;
  logic [ldh_pkg::OW_W:0]     wd;
  logic [ldh_pkg::OH_W:0]     ht;
  logic                       col_last, row_last;
  logic [1:0]                 nr_d, nc_d;
  logic [ldh_pkg::OROW_W-1:0] rv0_d, rv1_d, oy;
  logic [ldh_pkg::OCOL_W-1:0] cv0_d, cv1_d, ox;
  logic                       last_res;
  ldh_pkg::wvec_t             wx_d, wy_d;
  ldh_pkg::sum_t              sx, sy;
  ldh_pkg::num3_t             num_d;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_px  = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  // Effective frame size
  always_comb begin
    if (out_width_q == '0) begin
      ow_eff = ldh_pkg::OW_W'(1);
    end else if (out_width_q > ldh_pkg::OW_W'(ldh_pkg::LIM_OW)) begin
      ow_eff = ldh_pkg::OW_W'(ldh_pkg::LIM_OW);
    end else begin
      ow_eff = out_width_q;
    end
    if (out_height_q == '0) begin
      oh_eff = ldh_pkg::OH_W'(1);
    end else if (out_height_q > ldh_pkg::OH_W'(2048)) begin
      oh_eff = ldh_pkg::OH_W'(2048);
    end else begin
      oh_eff = out_height_q;
    end
    wd = {ow_eff, 1'b0};
    ht = {oh_eff, 1'b0};
  end

  // Output rows and columns that this source pixel completes
  always_comb begin
    logic [ldh_pkg::OW_W:0] cc;
    logic                   rhit, chit;
    cc       = (ldh_pkg::OW_W+1)'(col_q);
    col_last = (cc == wd - 1'b1);
    row_last = ((ldh_pkg::OH_W+1)'(row_q) == ht - 1'b1);
    rhit     = row_q[0] && (row_q >= ldh_pkg::ROW_W'(3));
    chit     = col_q[0] && (cc >= (ldh_pkg::OW_W+1)'(3));
    rv1_d    = ldh_pkg::OROW_W'(oh_eff - 1'b1);
    cv1_d    = ldh_pkg::OCOL_W'(ow_eff - 1'b1);
    if (rhit) begin
      rv0_d = ldh_pkg::OROW_W'((row_q - ldh_pkg::ROW_W'(3)) >> 1);
      nr_d  = row_last ? 2'd2 : 2'd1;
    end else begin
      rv0_d = rv1_d;
      nr_d  = row_last ? 2'd1 : 2'd0;
    end
    if (chit) begin
      cv0_d = ldh_pkg::OCOL_W'((cc - (ldh_pkg::OW_W+1)'(3)) >> 1);
      nc_d  = col_last ? 2'd2 : 2'd1;
    end else begin
      cv0_d = cv1_d;
      nc_d  = col_last ? 2'd1 : 2'd0;
    end
  end

  // Configuration and source position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q  <= ldh_pkg::OW_W'(256);
      out_height_q <= ldh_pkg::OH_W'(256);
      col_q        <= '0;
      row_q        <= '0;
      bank_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ldh_pkg::CFG_OUT_WIDTH:  out_width_q  <= cfg_data_i[ldh_pkg::OW_W-1:0];
        ldh_pkg::CFG_OUT_HEIGHT: out_height_q <= cfg_data_i[ldh_pkg::OH_W-1:0];
        default: ;
      endcase
      col_q  <= '0;
      row_q  <= '0;
      bank_q <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_q <= '0;
        if (row_last) begin
          row_q  <= '0;
          bank_q <= '0;
        end else begin
          row_q  <= row_q + 1'b1;
          bank_q <= (bank_q == 3'd4) ? 3'd0 : bank_q + 3'd1;
        end
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Line stores, one per bank
  for (genvar k = 0; k < ldh_pkg::LINES; k++) begin : g_line
    ldh_line_ram u_ram (
      .clk_i  (clk_i),
      .en_i   (accept),
      .we_i   (bank_q == 3'(k)),
      .addr_i (col_q),
      .wdata_i(in_px),
      .rdata_o(ram_rd[k])
    );
  end

  // New window column: oldest row first, current pixel last
  always_comb begin
    int idx;
    for (int i = 0; i < ldh_pkg::LINES; i++) begin
      idx = int'(bank_cap_q) + i;
      if (idx >= ldh_pkg::LINES) begin
        idx = idx - ldh_pkg::LINES;
      end
      new_col[i] = ram_rd[idx];
    end
    new_col[ldh_pkg::TAPS-1] = px_q;
  end

  // Chain of column cells, newest at the top
  for (genvar k = 0; k < ldh_pkg::TAPS; k++) begin : g_cell
    ldh_column_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(cell_ctrl),
      .col_i ((k == ldh_pkg::TAPS - 1) ? new_col : cell_col[(k + 1) % ldh_pkg::TAPS]),
      .wy_i  (wy_q),
      .wx_i  (wx_q[k]),
      .col_o (cell_col[k]),
      .prod_o(cell_prod[k])
    );
  end

  // Current output coordinate and weights
  assign oy       = a_q ? rv1_q : rv0_q;
  assign ox       = b_q ? cv1_q : cv0_q;
  assign last_res = ({1'b0, a_q} == nr_q - 2'd1) && ({1'b0, b_q} == nc_q - 2'd1);

  always_comb begin
    for (int j = 0; j < ldh_pkg::TAPS; j++) begin
      wx_d[j] = ldh_pkg::slot_weight(int'(cur_c_q), int'(ox), int'(wd), j);
      wy_d[j] = ldh_pkg::slot_weight(int'(cur_r_q), int'(oy), int'(ht), j);
    end
  end

  // Weight sums and numerators
  always_comb begin
    sx = '0;
    sy = '0;
    for (int j = 0; j < ldh_pkg::TAPS; j++) begin
      sx = sx + ldh_pkg::SUM_W'(wx_q[j]);
      sy = sy + ldh_pkg::SUM_W'(wy_q[j]);
    end
    for (int ch = 0; ch < 3; ch++) begin
      num_d[ch] = '0;
      for (int k = 0; k < ldh_pkg::TAPS; k++) begin
        num_d[ch] = num_d[ch] + ldh_pkg::NUM_W'(cell_prod[k][ch]);
      end
    end
  end

  ldh_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ldh_pkg::ST_IDLE:   if (accept) state_d = ldh_pkg::ST_LOAD;
      ldh_pkg::ST_LOAD:   state_d = (nr_q == 2'd0 || nc_q == 2'd0) ? ldh_pkg::ST_IDLE
                                                                   : ldh_pkg::ST_WGT;
      ldh_pkg::ST_WGT:    state_d = ldh_pkg::ST_VSUM;
      ldh_pkg::ST_VSUM:   state_d = ldh_pkg::ST_HPROD;
      ldh_pkg::ST_HPROD:  state_d = ldh_pkg::ST_HSUM;
      ldh_pkg::ST_HSUM:   state_d = ldh_pkg::ST_DSTART;
      ldh_pkg::ST_DSTART: state_d = ldh_pkg::ST_DWAIT;
      ldh_pkg::ST_DWAIT:  if (div_done) state_d = ldh_pkg::ST_EMIT;
      ldh_pkg::ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = last_res ? ldh_pkg::ST_IDLE : ldh_pkg::ST_WGT;
        end
      end
      default:            state_d = ldh_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready   = 1'b0;
    cell_ctrl       = '0;
    div_start       = 1'b0;
    out_ld          = 1'b0;
    case (state_q)
      ldh_pkg::ST_IDLE:   s_axis_tready   = 1'b1;
      ldh_pkg::ST_LOAD:   cell_ctrl.shift = 1'b1;
      ldh_pkg::ST_VSUM:   cell_ctrl.vsum  = 1'b1;
      ldh_pkg::ST_HPROD:  cell_ctrl.hprod = 1'b1;
      ldh_pkg::ST_DSTART: div_start       = 1'b1;
      ldh_pkg::ST_EMIT:   out_ld          = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ldh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Result iteration, row-major
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 1'b0;
      b_q <= 1'b0;
    end else if (state_q == ldh_pkg::ST_LOAD) begin
      a_q <= 1'b0;
      b_q <= 1'b0;
    end else if (out_ld && !last_res) begin
      if ({1'b0, b_q} == nc_q - 2'd1) begin
        b_q <= 1'b0;
        a_q <= 1'b1;
      end else begin
        b_q <= 1'b1;
      end
    end
  end

  // Capture the item and hold the datapath stages
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_c_q    <= col_q;
      cur_r_q    <= row_q;
      bank_cap_q <= bank_q;
      px_q       <= in_px;
      nr_q       <= nr_d;
      nc_q       <= nc_d;
      rv0_q      <= rv0_d;
      rv1_q      <= rv1_d;
      cv0_q      <= cv0_d;
      cv1_q      <= cv1_d;
    end
    if (state_q == ldh_pkg::ST_WGT) begin
      wx_q <= wx_d;
      wy_q <= wy_d;
    end
    if (state_q == ldh_pkg::ST_VSUM) begin
      den_q <= ldh_pkg::DEN_W'(sx * sy);
    end
    if (state_q == ldh_pkg::ST_HSUM) begin
      num_q <= num_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_ld) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      m_data_q <= {5'b0, oy, ox, quot[2], quot[1], quot[0]};
      m_last_q <= last_res;
      m_user_q <= (oy == ldh_pkg::OROW_W'(oh_eff - 1'b1)) &&
                  (ox == ldh_pkg::OCOL_W'(ow_eff - 1'b1));
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

@@ sv/ldh_checker.sv @@
// ----------------------------------------------------------------------------
// ldh_checker: port-level checks of the downscaler
// Output hold, frame-end ordering and single-item intake.
// ----------------------------------------------------------------------------
`default_nettype none

module ldh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Frame end is always the last result of its pixel
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without run end");

  // One pixel at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

endmodule

bind lanczos3_half_downscaler_top ldh_checker u_chk (.*);

`default_nettype wire
